### rtl/etbwd_pkg.sv
// ----------------------------------------------------------------------------
// Two-burst wake detector package
// Shared constants, phase codes and the serial multiplier status type.
// ----------------------------------------------------------------------------
package etbwd_pkg;

	// Default largest frame length in samples.
	localparam int DEF_MAX_FRAME = 4096;

	// Multiplicand width of the shared serial multiplier.
	localparam int MUL_AW = 32;

	// Configuration register indexes.
	localparam logic [2:0] REG_ENABLE = 3'd0;
	localparam logic [2:0] REG_SPEECH = 3'd1;
	localparam logic [2:0] REG_QUIET  = 3'd2;
	localparam logic [2:0] REG_LENGTH = 3'd3;

	// Configuration reset values.
	localparam logic        RST_ENABLE = 1'b1;
	localparam logic [15:0] RST_SPEECH = 16'd1200;
	localparam logic [15:0] RST_QUIET  = 16'd600;
	localparam logic [12:0] RST_LENGTH = 13'd1600;

	// Detector phases.
	localparam logic [2:0] PH_IDLE = 3'd0;
	localparam logic [2:0] PH_ONE  = 3'd1;
	localparam logic [2:0] PH_GAP  = 3'd2;
	localparam logic [2:0] PH_TWO  = 3'd3;
	localparam logic [2:0] PH_PEND = 3'd4;

	// Frame count limits of the phase machine.
	localparam logic [4:0] BURST_MIN = 5'd2;
	localparam logic [4:0] BURST_MAX = 5'd15;
	localparam logic [4:0] GAP_MAX   = 5'd8;
	localparam logic [4:0] QUIET_MAX = 5'd20;

	typedef struct packed {
		logic busy;
		logic done;
	} mul_stat_t;

endpackage

### rtl/etbwd_sermul.sv
// ----------------------------------------------------------------------------
// Serial shift-add multiplier
// Unsigned product of an AW-bit and a BW-bit operand, one multiplier bit per
// cycle. The product is valid in the cycle where done is high.
// ----------------------------------------------------------------------------
module etbwd_sermul
	import etbwd_pkg::*;
#(
	parameter int AW = 32,
	parameter int BW = 17
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [AW-1:0]    a,
	input  logic [BW-1:0]    b,
	output mul_stat_t        stat,
	output logic [AW+BW-1:0] prod
);

	localparam int CW = (BW > 1) ? $clog2(BW) : 1;

	logic [AW+BW-1:0] acc_q;
	logic [AW-1:0]    mcand_q;
	logic [CW-1:0]    count_q;
	logic             busy_q;
	logic             done_q;
	logic [AW:0]      sum;

	// The upper half takes the multiplicand when the lowest multiplier bit is
	// set, then the whole word shifts right by one.
	assign sum = {1'b0, acc_q[AW+BW-1:BW]} + (acc_q[0] ? {1'b0, mcand_q} : {(AW+1){1'b0}});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			count_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q  <= 1'b1;
				count_q <= '0;
			end else if (busy_q) begin
				count_q <= count_q + 1'b1;
				if (count_q == CW'(BW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q   <= {{AW{1'b0}}, b};
			mcand_q <= a;
		end else if (busy_q) begin
			acc_q <= {sum, acc_q[BW-1:1]};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign prod      = acc_q;

endmodule

### rtl/energy_two_burst_wake_detector.sv
// ----------------------------------------------------------------------------
// Two-burst energy wake detector
// Sums sample squares per frame, classifies each frame as speech or quiet and
// runs a two-burst phase machine, giving one result beat per closed frame.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake                  | payload
//  ---------+-----------+----------------------------+---------------------------
//  sample   | in        | sample_valid/sample_ready  | sample
//  result   | out       | result_valid/result_ready  | wake_detected, frame_is_speech,
//           |           |                            | frame_is_quiet, detector_phase,
//           |           |                            | detection_total
//  cfg      | in        | cfg_valid/cfg_ready        | cfg_index, cfg_data
//
// A sample is accepted, then the shared serial multiplier squares its magnitude
// and the square is added in. A sample that closes a frame runs four more
// multiplier passes for the two thresholds before its result beat is registered.
// The result register frees the input side; only a new frame end waits for
// it to drain. Reset restores the register defaults and clears all counts.
// ----------------------------------------------------------------------------
module energy_two_burst_wake_detector
	import etbwd_pkg::*;
#(
	parameter int MAX_FRAME = DEF_MAX_FRAME
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        sample_valid,
	output logic        sample_ready,
	input  logic [15:0] sample,
	output logic        result_valid,
	input  logic        result_ready,
	output logic        wake_detected,
	output logic        frame_is_speech,
	output logic        frame_is_quiet,
	output logic [2:0]  detector_phase,
	output logic [31:0] detection_total,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	localparam int NW = $clog2(MAX_FRAME + 1);
	localparam int BW = (NW > 17) ? NW : 17;
	localparam int AW = MUL_AW;
	localparam int PW = AW + BW;
	localparam int EW = 31 + NW;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_SQR  = 3'd1;
	localparam logic [2:0] ST_SL2  = 3'd2;
	localparam logic [2:0] ST_SLN  = 3'd3;
	localparam logic [2:0] ST_QL2  = 3'd4;
	localparam logic [2:0] ST_QLN  = 3'd5;
	localparam logic [2:0] ST_EMIT = 3'd6;

	// Configuration.
	logic        enable_q;
	logic [15:0] speech_level_q;
	logic [15:0] quiet_level_q;
	logic [12:0] frame_length_q;

	// Frame and detector state.
	logic [2:0]    state_q;
	logic [NW-1:0] frame_pos_q;
	logic [EW-1:0] energy_q;
	logic [EW-1:0] energy_frame_q;
	logic          close_q;
	logic          speech_q;
	logic          quiet_q;
	logic [2:0]    phase_q;
	logic [4:0]    pf_q;
	logic [4:0]    qrun_q;
	logic [31:0]   count_q;

	// Result register.
	logic        out_valid_q;
	logic        out_wake_q;
	logic        out_speech_q;
	logic        out_quiet_q;
	logic [2:0]  out_phase_q;
	logic [31:0] out_total_q;

	logic          accept;
	logic [16:0]   mag;
	logic [NW-1:0] n_eff;
	logic [NW-1:0] pos_next;
	logic          close_now;
	logic          mul_start;
	logic [AW-1:0] mul_a;
	logic [BW-1:0] mul_b;
	mul_stat_t     mstat;
	logic [PW-1:0] prod;
	logic          out_free;
	logic          emit;

	logic [2:0]  ph_n;
	logic [4:0]  pf_n;
	logic [4:0]  pf_inc;
	logic [4:0]  qr_n;
	logic [4:0]  qr_inc;
	logic [31:0] cnt_n;
	logic        wake_n;

	assign cfg_ready    = 1'b1;
	assign sample_ready = (state_q == ST_IDLE);
	assign accept       = sample_valid && sample_ready;

	assign mag = sample[15] ? (17'h10000 - {1'b0, sample}) : {1'b0, sample};

	always_comb begin
		if (frame_length_q == 13'd0) begin
			n_eff = NW'(1);
		end else if (32'(frame_length_q) > 32'(MAX_FRAME)) begin
			n_eff = NW'(MAX_FRAME);
		end else begin
			n_eff = NW'(frame_length_q);
		end
	end

	assign pos_next  = frame_pos_q + 1'b1;
	assign close_now = (pos_next >= n_eff);

	// Operand selection for the shared multiplier, one pass per state.
	always_comb begin
		mul_start = 1'b0;
		mul_a     = AW'(mag);
		mul_b     = BW'(mag);
		unique case (state_q)
			ST_IDLE: begin
				mul_start = accept && enable_q;
			end
			ST_SQR: begin
				mul_start = mstat.done && close_q;
				mul_a     = AW'(speech_level_q);
				mul_b     = BW'(speech_level_q);
			end
			ST_SL2: begin
				mul_start = mstat.done;
				mul_a     = prod[AW-1:0];
				mul_b     = BW'(n_eff);
			end
			ST_SLN: begin
				mul_start = mstat.done;
				mul_a     = AW'(quiet_level_q);
				mul_b     = BW'(quiet_level_q);
			end
			ST_QL2: begin
				mul_start = mstat.done;
				mul_a     = prod[AW-1:0];
				mul_b     = BW'(n_eff);
			end
			ST_QLN, ST_EMIT: begin
				mul_start = 1'b0;
			end
			default: begin
				mul_start = 1'b0;
			end
		endcase
	end

	etbwd_sermul #(
		.AW(AW),
		.BW(BW)
	) u_mul (
		.clk   (clk),
		.arst_n(arst_n),
		.start (mul_start),
		.a     (mul_a),
		.b     (mul_b),
		.stat  (mstat),
		.prod  (prod)
	);

	// Phase machine step for one closed frame.
	always_comb begin
		ph_n   = phase_q;
		pf_n   = pf_q;
		qr_n   = qrun_q;
		cnt_n  = count_q;
		wake_n = 1'b0;
		pf_inc = pf_q + 1'b1;
		qr_inc = qrun_q + 1'b1;
		unique case (phase_q)
			PH_IDLE: begin
				if (speech_q) begin
					ph_n = PH_ONE;
					pf_n = '0;
				end
			end
			PH_ONE: begin
				pf_n = pf_inc;
				if (!speech_q && pf_inc > BURST_MIN) begin
					ph_n = PH_GAP;
					pf_n = '0;
				end else if (pf_inc > BURST_MAX) begin
					ph_n = PH_IDLE;
				end
			end
			PH_GAP: begin
				pf_n = pf_inc;
				if (speech_q) begin
					ph_n = PH_TWO;
					pf_n = '0;
				end else if (pf_inc > GAP_MAX) begin
					ph_n = PH_IDLE;
				end
			end
			PH_TWO: begin
				pf_n = pf_inc;
				if (!speech_q && pf_inc > BURST_MIN) begin
					ph_n = PH_PEND;
				end else if (pf_inc > BURST_MAX) begin
					ph_n = PH_IDLE;
				end
			end
			PH_PEND: begin
				ph_n   = PH_IDLE;
				wake_n = 1'b1;
				cnt_n  = count_q + 1'b1;
			end
			default: begin
				ph_n = PH_IDLE;
			end
		endcase
		// The reporting frame leaves the quiet run untouched.
		if (!wake_n) begin
			if (quiet_q) begin
				if (qr_inc > QUIET_MAX) begin
					ph_n = PH_IDLE;
					qr_n = '0;
				end else begin
					qr_n = qr_inc;
				end
			end else begin
				qr_n = '0;
			end
		end
	end

	assign out_free = !out_valid_q || result_ready;
	assign emit     = (state_q == ST_EMIT) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q       <= RST_ENABLE;
			speech_level_q <= RST_SPEECH;
			quiet_level_q  <= RST_QUIET;
			frame_length_q <= RST_LENGTH;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_ENABLE: enable_q       <= cfg_data[0];
				REG_SPEECH: speech_level_q <= cfg_data;
				REG_QUIET:  quiet_level_q  <= cfg_data;
				REG_LENGTH: frame_length_q <= cfg_data[12:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			frame_pos_q <= '0;
			energy_q    <= '0;
			close_q     <= 1'b0;
			phase_q     <= PH_IDLE;
			pf_q        <= '0;
			qrun_q      <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// A new beat may replace the one leaving in the same cycle.
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (result_valid && result_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept && enable_q) begin
						close_q     <= close_now;
						frame_pos_q <= close_now ? '0 : pos_next;
						state_q     <= ST_SQR;
					end
				end
				ST_SQR: begin
					if (mstat.done) begin
						if (close_q) begin
							energy_q <= '0;
							state_q  <= ST_SL2;
						end else begin
							energy_q <= energy_q + EW'(prod);
							state_q  <= ST_IDLE;
						end
					end
				end
				ST_SL2: begin
					if (mstat.done) begin
						state_q <= ST_SLN;
					end
				end
				ST_SLN: begin
					if (mstat.done) begin
						state_q <= ST_QL2;
					end
				end
				ST_QL2: begin
					if (mstat.done) begin
						state_q <= ST_QLN;
					end
				end
				ST_QLN: begin
					if (mstat.done) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						phase_q <= ph_n;
						pf_q    <= pf_n;
						qrun_q  <= qr_n;
						count_q <= cnt_n;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_SQR && mstat.done && close_q) begin
			energy_frame_q <= energy_q + EW'(prod);
		end
		if (state_q == ST_SLN && mstat.done) begin
			speech_q <= (PW'(energy_frame_q) > prod);
		end
		if (state_q == ST_QLN && mstat.done) begin
			quiet_q <= (PW'(energy_frame_q) < prod);
		end
		if (emit) begin
			out_wake_q   <= wake_n;
			out_speech_q <= speech_q;
			out_quiet_q  <= quiet_q;
			out_phase_q  <= ph_n;
			out_total_q  <= cnt_n;
		end
	end

	assign result_valid    = out_valid_q;
	assign wake_detected   = out_wake_q;
	assign frame_is_speech = out_speech_q;
	assign frame_is_quiet  = out_quiet_q;
	assign detector_phase  = out_phase_q;
	assign detection_total = out_total_q;

	// A detection always leaves the phase machine idle.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && wake_detected |-> detector_phase == PH_IDLE)
		else $error("wake result with non-idle phase");

	// The detection count moves only together with a registered wake result.
	assert property (@(posedge clk) disable iff (!arst_n)
		count_q != $past(count_q) |-> result_valid && wake_detected
			&& detection_total == count_q)
		else $error("detection count changed without a wake result");

	// The multiplier runs only while a sample or frame end is in progress.
	assert property (@(posedge clk) disable iff (!arst_n)
		mstat.busy |-> state_q != ST_IDLE && state_q != ST_EMIT)
		else $error("multiplier busy outside a pass");

	// The frame position never reaches the largest frame length.
	assert property (@(posedge clk) disable iff (!arst_n)
		frame_pos_q < NW'(MAX_FRAME))
		else $error("frame position out of range");

endmodule

### tb/tb_energy_two_burst_wake_detector.sv
// ----------------------------------------------------------------------------
// Two-burst wake detector testbench
// Streams audio samples through the detector and checks every frame beat
// against an in-bench model of frame energy, speech and quiet tests and the
// burst phase machine. A short table of hand-picked beats comes first, then
// shaped random bursts under random configuration, one full-size frame and a
// final stretch with no back-pressure.
// ----------------------------------------------------------------------------
module tb_energy_two_burst_wake_detector;
	import etbwd_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// Register indexes that decode to nothing.
	localparam logic [2:0] REG_NONE_LO = 3'd4;
	localparam logic [2:0] REG_NONE_HI = 3'd7;

	localparam int SETTLE_CYCLES  = 120;
	localparam int DRAIN_CYCLES   = 150;
	localparam int RANDOM_SAMPLES = 700;

	typedef struct packed {
		logic        wake;
		logic        speech;
		logic        quiet;
		logic [2:0]  phase;
		logic [31:0] total;
	} frame_verdict_t;

	typedef enum {CLS_LOUD, CLS_MID, CLS_SOFT, CLS_ANY, CLS_FULL} frame_class_t;
	typedef enum {ROW_CFG, ROW_SMP, ROW_SOFT_FRAME} plan_kind_t;

	typedef struct {
		plan_kind_t     kind;
		logic [2:0]     idx;
		logic [15:0]    val;
		bit             typed;
		frame_verdict_t want;
	} plan_entry_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        sample_valid = 1'b0;
	logic        sample_ready;
	logic [15:0] sample = '0;
	logic        result_valid;
	logic        result_ready = 1'b0;
	logic        wake_detected;
	logic        frame_is_speech;
	logic        frame_is_quiet;
	logic [2:0]  detector_phase;
	logic [31:0] detection_total;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;

	// Model copy of the registers and the detector state.
	logic        cfg_enable = RST_ENABLE;
	logic [15:0] cfg_speech = RST_SPEECH;
	logic [15:0] cfg_quiet = RST_QUIET;
	logic [12:0] cfg_length = RST_LENGTH;
	int          frame_pos = 0;
	logic [63:0] frame_energy = '0;
	logic [2:0]  det_phase = PH_IDLE;
	int          phase_count = 0;
	int          quiet_count = 0;
	logic [31:0] wake_count = '0;

	frame_verdict_t verdict_q[$];

	bit idle_on = 1'b0;
	int stall_left = 0;
	int err_count = 0;
	int frames_checked = 0;
	int wakes_seen = 0;
	int samples_taken = 0;
	int cfg_writes = 0;

	energy_two_burst_wake_detector dut (.*);

	initial begin
		forever #2 clk = ~clk;
	end

	function automatic frame_verdict_t verdict(logic w, logic s, logic q, logic [2:0] ph,
			logic [31:0] tot);
		frame_verdict_t v;
		v.wake = w;
		v.speech = s;
		v.quiet = q;
		v.phase = ph;
		v.total = tot;
		return v;
	endfunction

	function automatic plan_entry_t entry(plan_kind_t k, logic [2:0] i, logic [15:0] v,
			bit t, frame_verdict_t w);
		plan_entry_t e;
		e.kind = k;
		e.idx = i;
		e.val = v;
		e.typed = t;
		e.want = w;
		return e;
	endfunction

	function automatic void apply_reg(logic [2:0] idx, logic [15:0] val);
		case (idx)
			REG_ENABLE: cfg_enable = val[0];
			REG_SPEECH: cfg_speech = val;
			REG_QUIET:  cfg_quiet = val;
			REG_LENGTH: cfg_length = val[12:0];
			default: ;
		endcase
	endfunction

	// Adds one sample to the frame; returns 1 with the frame verdict when it closes.
	function automatic bit take_sample(input logic [15:0] s, output frame_verdict_t v);
		logic [63:0] mag, n, sp_lim, qt_lim;
		bit sp, qt, wk;
		v = '0;
		wk = 1'b0;
		if (!cfg_enable)
			return 1'b0;
		samples_taken++;
		mag = s[15] ? 64'(17'h10000 - 17'(s)) : 64'(s);
		frame_energy = frame_energy + mag * mag;
		frame_pos++;
		if (cfg_length == 0)
			n = 64'd1;
		else if (cfg_length > DEF_MAX_FRAME)
			n = 64'(DEF_MAX_FRAME);
		else
			n = 64'(cfg_length);
		if (64'(frame_pos) < n)
			return 1'b0;

		sp_lim = 64'(cfg_speech) * 64'(cfg_speech) * n;
		qt_lim = 64'(cfg_quiet) * 64'(cfg_quiet) * n;
		sp = frame_energy > sp_lim;
		qt = frame_energy < qt_lim;
		frame_energy = '0;
		frame_pos = 0;

		case (det_phase)
			PH_IDLE: begin
				if (sp) begin
					det_phase = PH_ONE;
					phase_count = 0;
				end
			end
			PH_ONE: begin
				phase_count++;
				if (!sp && phase_count > BURST_MIN) begin
					det_phase = PH_GAP;
					phase_count = 0;
				end else if (phase_count > BURST_MAX) begin
					det_phase = PH_IDLE;
				end
			end
			PH_GAP: begin
				phase_count++;
				if (sp) begin
					det_phase = PH_TWO;
					phase_count = 0;
				end else if (phase_count > GAP_MAX) begin
					det_phase = PH_IDLE;
				end
			end
			PH_TWO: begin
				phase_count++;
				if (!sp && phase_count > BURST_MIN)
					det_phase = PH_PEND;
				else if (phase_count > BURST_MAX)
					det_phase = PH_IDLE;
			end
			default: begin
				det_phase = PH_IDLE;
				wk = 1'b1;
				wake_count++;
			end
		endcase

		// The reporting frame leaves the quiet run alone.
		if (!wk) begin
			if (qt) begin
				quiet_count++;
				if (quiet_count > QUIET_MAX) begin
					det_phase = PH_IDLE;
					quiet_count = 0;
				end
			end else begin
				quiet_count = 0;
			end
		end

		v = verdict(wk, sp, qt, det_phase, wake_count);
		return 1'b1;
	endfunction

	// Picks a sample whose magnitude puts a whole frame of them in the given class.
	function automatic logic [15:0] pick_sample(frame_class_t c);
		int lo, hi, mag;
		case (c)
			CLS_LOUD: begin
				lo = int'(cfg_speech) + 1;
				hi = 32768;
			end
			CLS_MID: begin
				lo = int'(cfg_quiet);
				hi = (cfg_speech > 16'd32768) ? 32768 : int'(cfg_speech);
			end
			CLS_SOFT: begin
				lo = 0;
				hi = (cfg_quiet > 16'd32768) ? 32768 : int'(cfg_quiet) - 1;
			end
			CLS_FULL: return 16'h8000;
			default: begin
				lo = 1;
				hi = 0;
			end
		endcase
		if (lo > hi)
			return 16'($urandom);
		mag = $urandom_range(hi, lo);
		if (mag == 32768)
			return 16'h8000;
		if ($urandom_range(0, 1) != 0)
			return 16'(-mag);
		return 16'(mag);
	endfunction

	task automatic push_sample(input logic [15:0] s, input bit use_typed,
			input frame_verdict_t tv, output bit closed);
		frame_verdict_t v;
		if (idle_on && $urandom_range(0, 5) == 0) begin
			sample_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		sample_valid <= 1'b1;
		sample <= s;
		@(posedge clk);
		while (!sample_ready) @(posedge clk);
		closed = take_sample(s, v);
		if (closed)
			verdict_q.push_back(use_typed ? tv : v);
	endtask

	task automatic send_frame(input frame_class_t c, input bit use_typed,
			input frame_verdict_t tv);
		bit closed;
		closed = 1'b0;
		if (!cfg_enable)
			return;
		do
			push_sample(pick_sample(c), use_typed, tv, closed);
		while (!closed);
	endtask

	// Holds the sender until every frame beat is back and the block is quiet.
	task automatic settle();
		sample_valid <= 1'b0;
		while (verdict_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [2:0] idx, input logic [15:0] val);
		settle();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		apply_reg(idx, val);
		cfg_writes++;
		@(posedge clk);
	endtask

	task automatic reconfigure();
		int sl, ql, len;
		bit closed;
		if ($urandom_range(0, 7) == 0) begin
			cfg_write(REG_ENABLE, 16'h0000);
			repeat ($urandom_range(1, 4)) push_sample(16'($urandom), 1'b0, '0, closed);
			cfg_write(REG_ENABLE, 16'($urandom) | 16'h0001);
		end
		if ($urandom_range(0, 9) == 0)
			cfg_write(3'($urandom_range(REG_NONE_HI, REG_NONE_LO)), 16'($urandom));
		case ($urandom_range(0, 9))
			0: sl = 0;
			1: sl = 32768;
			2: sl = $urandom_range(0, 65535);
			default: sl = $urandom_range(200, 6000);
		endcase
		case ($urandom_range(0, 9))
			0: ql = 0;
			1: ql = 32768;
			2: ql = $urandom_range(0, 65535);
			default: ql = $urandom_range(0, (sl > 6000) ? 6000 : sl);
		endcase
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5: len = $urandom_range(1, 3);
			6, 7: len = $urandom_range(4, 12);
			8: len = 0;
			default: len = $urandom_range(13, 24);
		endcase
		if ($urandom_range(0, 4) != 0)
			cfg_write(REG_SPEECH, 16'(sl));
		if ($urandom_range(0, 4) != 0)
			cfg_write(REG_QUIET, 16'(ql));
		// The top bits of the length write lie outside the register.
		if ($urandom_range(0, 4) != 0)
			cfg_write(REG_LENGTH, 16'(len) | (16'($urandom) & 16'hE000));
	endtask

	// Mostly a two-burst shape with random lengths, otherwise quiet runs or noise.
	task automatic run_pattern();
		frame_class_t seq[$];
		int shape, k;
		shape = $urandom_range(0, 9);
		if (shape < 7) begin
			repeat ($urandom_range(1, ($urandom_range(0, 3) == 0) ? 17 : 5))
				seq.push_back(CLS_LOUD);
			repeat ($urandom_range(1, ($urandom_range(0, 3) == 0) ? 11 : 4))
				seq.push_back(($urandom_range(0, 1) != 0) ? CLS_SOFT : CLS_MID);
			repeat ($urandom_range(1, ($urandom_range(0, 3) == 0) ? 17 : 5))
				seq.push_back(CLS_LOUD);
			repeat ($urandom_range(1, 3))
				seq.push_back(($urandom_range(0, 1) != 0) ? CLS_SOFT : CLS_MID);
			seq.push_back(frame_class_t'($urandom_range(0, 3)));
		end else if (shape == 7) begin
			repeat ($urandom_range(18, 24)) seq.push_back(CLS_SOFT);
		end else begin
			repeat ($urandom_range(1, 12)) seq.push_back(frame_class_t'($urandom_range(0, 3)));
		end
		for (k = 0; k < seq.size(); k++)
			send_frame(seq[k], 1'b0, '0);
	endtask

	// Result ready drops in random bursts while idling is on.
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			result_ready <= (stall_left == 1);
		end else if (idle_on && $urandom_range(0, 7) == 0) begin
			stall_left <= $urandom_range(1, 8);
			result_ready <= 1'b0;
		end else begin
			result_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		frame_verdict_t got, want;
		if (arst_n && result_valid && result_ready) begin
			got = {wake_detected, frame_is_speech, frame_is_quiet, detector_phase,
				detection_total};
			if (verdict_q.size() == 0) begin
				err_count++;
				if (err_count <= 10)
					$display("Result beat with no frame pending: wake=%0b phase=%0d total=%0d",
						got.wake, got.phase, got.total);
			end else begin
				want = verdict_q.pop_front();
				frames_checked++;
				if (got.wake)
					wakes_seen++;
				if (got !== want) begin
					err_count++;
					if (err_count <= 10) begin
						$display("Frame %0d mismatch: expected wake=%0b speech=%0b quiet=%0b phase=%0d total=%0d",
							frames_checked, want.wake, want.speech, want.quiet, want.phase,
							want.total);
						$display("  got wake=%0b speech=%0b quiet=%0b phase=%0d total=%0d",
							got.wake, got.speech, got.quiet, got.phase, got.total);
					end
				end
			end
		end
	end

	initial begin
		plan_entry_t plan[$];
		bit closed;
		int base_taken;

		// One full default frame of soft audio, then single-sample frames that
		// walk both bursts to a detection.
		plan.push_back(entry(ROW_SOFT_FRAME, '0, '0, 1, verdict(0, 0, 1, PH_IDLE, 0)));
		plan.push_back(entry(ROW_CFG, REG_LENGTH, 16'd0, 0, '0));
		plan.push_back(entry(ROW_SMP, '0, 16'h0000, 1, verdict(0, 0, 1, PH_IDLE, 0)));
		plan.push_back(entry(ROW_SMP, '0, 16'h8000, 1, verdict(0, 1, 0, PH_ONE, 0)));
		plan.push_back(entry(ROW_SMP, '0, 16'h7FFF, 0, '0));
		plan.push_back(entry(ROW_SMP, '0, 16'd1200, 1, verdict(0, 0, 0, PH_ONE, 0)));
		plan.push_back(entry(ROW_SMP, '0, 16'd1201, 0, '0));
		plan.push_back(entry(ROW_SMP, '0, 16'd599, 0, '0));
		plan.push_back(entry(ROW_SMP, '0, 16'd600, 1, verdict(0, 0, 0, PH_GAP, 0)));
		plan.push_back(entry(ROW_SMP, '0, 16'hFB4F, 0, '0));
		plan.push_back(entry(ROW_SMP, '0, 16'd4000, 0, '0));
		plan.push_back(entry(ROW_SMP, '0, 16'd4000, 0, '0));
		plan.push_back(entry(ROW_SMP, '0, 16'h0000, 0, '0));
		plan.push_back(entry(ROW_SMP, '0, 16'h0000, 1, verdict(1, 0, 1, PH_IDLE, 1)));
		// Disabled samples must leave no trace.
		plan.push_back(entry(ROW_CFG, REG_ENABLE, 16'h0000, 0, '0));
		plan.push_back(entry(ROW_SMP, '0, 16'h7FFF, 0, '0));
		plan.push_back(entry(ROW_SMP, '0, 16'h5555, 0, '0));
		plan.push_back(entry(ROW_CFG, REG_ENABLE, 16'hFFFF, 0, '0));
		plan.push_back(entry(ROW_CFG, REG_SPEECH, 16'h0000, 0, '0));
		plan.push_back(entry(ROW_CFG, REG_QUIET, 16'h0000, 0, '0));
		plan.push_back(entry(ROW_SMP, '0, 16'h0000, 1, verdict(0, 0, 0, PH_IDLE, 1)));
		plan.push_back(entry(ROW_SMP, '0, 16'h0001, 1, verdict(0, 1, 0, PH_ONE, 1)));
		plan.push_back(entry(ROW_CFG, REG_SPEECH, 16'hFFFF, 0, '0));
		plan.push_back(entry(ROW_CFG, REG_QUIET, 16'hFFFF, 0, '0));
		plan.push_back(entry(ROW_SMP, '0, 16'h8000, 0, '0));
		plan.push_back(entry(ROW_CFG, REG_NONE_LO, 16'h0000, 0, '0));
		plan.push_back(entry(ROW_CFG, REG_NONE_HI, 16'h0003, 0, '0));
		plan.push_back(entry(ROW_SMP, '0, 16'h7FFF, 0, '0));
		// Shortening the frame after two samples closes it on the next one.
		plan.push_back(entry(ROW_CFG, REG_LENGTH, 16'd3, 0, '0));
		plan.push_back(entry(ROW_SMP, '0, 16'h2AAA, 0, '0));
		plan.push_back(entry(ROW_SMP, '0, 16'hD555, 0, '0));
		plan.push_back(entry(ROW_CFG, REG_LENGTH, 16'd1, 0, '0));
		plan.push_back(entry(ROW_SMP, '0, 16'h0000, 0, '0));
		// Full-scale sample against full-scale levels: energy equals both limits.
		plan.push_back(entry(ROW_CFG, REG_SPEECH, 16'h8000, 0, '0));
		plan.push_back(entry(ROW_CFG, REG_QUIET, 16'h8000, 0, '0));
		plan.push_back(entry(ROW_SMP, '0, 16'h8000, 0, '0));

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		idle_on <= 1'b1;
		foreach (plan[i]) begin
			case (plan[i].kind)
				ROW_CFG: cfg_write(plan[i].idx, plan[i].val);
				ROW_SMP: push_sample(plan[i].val, plan[i].typed, plan[i].want, closed);
				default: send_frame(CLS_SOFT, plan[i].typed, plan[i].want);
			endcase
		end

		base_taken = samples_taken;
		while (samples_taken - base_taken < RANDOM_SAMPLES) begin
			reconfigure();
			idle_on <= ($urandom_range(0, 3) != 0);
			repeat ($urandom_range(1, 3)) run_pattern();
		end

		// A length beyond the limit saturates to the largest frame.
		cfg_write(REG_LENGTH, 16'hFFFF);
		cfg_write(REG_SPEECH, 16'h8000);
		cfg_write(REG_QUIET, 16'h8000);
		send_frame(CLS_FULL, 1'b0, '0);

		idle_on <= 1'b0;
		cfg_write(REG_LENGTH, 16'd2);
		cfg_write(REG_SPEECH, 16'd1000);
		cfg_write(REG_QUIET, 16'd400);
		repeat (4) run_pattern();

		sample_valid <= 1'b0;
		while (verdict_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Covered %0d samples taken and %0d frames checked, %0d of them wake reports.",
			samples_taken, frames_checked, wakes_seen);
		$display("Made %0d register writes over zero, full-scale and saturating settings.",
			cfg_writes);
		if (err_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	// Far beyond the slowest correct run.
	initial begin
		#10_000_000;
		$display("Timeout with %0d frame beats still pending.", verdict_q.size());
		$display("Simulation FAILED");
		$finish;
	end

endmodule

### energy_two_burst_wake_detector.f
rtl/etbwd_pkg.sv
rtl/etbwd_sermul.sv
rtl/energy_two_burst_wake_detector.sv
tb/tb_energy_two_burst_wake_detector.sv
